[src/dptbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptbc_pkg
// Shared widths, register indexes and control types for the dark pixel tint,
// brightness and contrast pipeline.
// ----------------------------------------------------------------------------
package dptbc_pkg;

	// Channel and register widths
	localparam int CH_W      = 8;
	localparam int GAIN_W    = 12;
	localparam int OFF_W     = 9;
	localparam int CF_W      = 12;
	localparam int THR_W     = 8;
	localparam int CFG_W     = 12;
	localparam int IDX_W     = 3;
	localparam int NUM_LANES = 3;
	localparam int PIX_W     = NUM_LANES * CH_W;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_BLUE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_GREEN = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_RED   = 3'd2;
	localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 3'd3;
	localparam logic [IDX_W-1:0] REG_CONTRAST   = 3'd4;
	localparam logic [IDX_W-1:0] REG_DARK_THR   = 3'd5;

	// Reset values
	localparam logic [GAIN_W-1:0] GAIN_RST     = 12'd256;
	localparam logic [OFF_W-1:0]  OFF_RST      = 9'd0;
	localparam logic [CF_W-1:0]   CF_RST       = 12'd256;
	localparam logic [THR_W-1:0]  THR_RST      = 8'd100;

	// Levels
	localparam logic [CH_W-1:0] CH_MAX    = 8'd255;
	localparam logic [CH_W-1:0] MID_LEVEL = 8'd128;

	// Per-stage advance strobes handed to the lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} dptbc_adv_t;

	// Settings shared by every lane
	typedef struct packed {
		logic signed [OFF_W-1:0] offset;
		logic [CF_W-1:0]         contrast;
	} dptbc_cfg_t;

endpackage
`default_nettype wire

[src/dptbc_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dptbc_lane
// One colour channel: gain for dark pixels with saturation, brightness offset
// with clamp, contrast about mid level with clamp. Five registered stages.
// ----------------------------------------------------------------------------
module dptbc_lane (
	input  wire                          clk,
	input  dptbc_pkg::dptbc_adv_t        adv,
	input  wire [dptbc_pkg::CH_W-1:0]    pix_in,
	input  wire                          dark_s1,
	input  wire [dptbc_pkg::GAIN_W-1:0]  gain,
	input  dptbc_pkg::dptbc_cfg_t        cfg,
	output logic [dptbc_pkg::CH_W-1:0]   pix_out
);
	import dptbc_pkg::*;

	localparam int PROD_W = CH_W + GAIN_W;
	localparam int SUM_W  = CH_W + 2;
	localparam int NUM_W  = CH_W + CF_W + 2;

	logic [CH_W-1:0]          pix_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic [CH_W-1:0]          pix_s2;
	logic                     dark_s2;
	logic [CH_W-1:0]          gained;
	logic signed [SUM_W-1:0]  sum;
	logic [CH_W-1:0]          adj_s3;
	logic signed [NUM_W-1:0]  diff_x;
	logic signed [NUM_W-1:0]  cf_x;
	logic signed [NUM_W-1:0]  num_s4;
	logic [CH_W-1:0]          res_s5;

	// Stage 1: take the channel in
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			pix_s1 <= pix_in;
		end
	end

	// Stage 2: gain product, keep the raw channel beside it
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= PROD_W'(pix_s1) * PROD_W'(gain);
			pix_s2  <= pix_s1;
			dark_s2 <= dark_s1;
		end
	end

	// Stage 3: saturate the gain result, add brightness and clamp
	always_comb begin
		if (!dark_s2) begin
			gained = pix_s2;
		end else if (|prod_s2[PROD_W-1:2*CH_W]) begin
			gained = CH_MAX;
		end else begin
			gained = prod_s2[2*CH_W-1:CH_W];
		end
		sum = $signed({2'b00, gained}) + SUM_W'(cfg.offset);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			if (sum[SUM_W-1]) begin
				adj_s3 <= '0;
			end else if (sum[SUM_W-2]) begin
				adj_s3 <= CH_MAX;
			end else begin
				adj_s3 <= sum[CH_W-1:0];
			end
		end
	end

	// Stage 4: scale the distance from mid level
	always_comb begin
		diff_x = $signed(NUM_W'(adj_s3)) - $signed(NUM_W'(MID_LEVEL));
		cf_x   = $signed(NUM_W'(cfg.contrast));
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			num_s4 <= diff_x * cf_x + $signed(NUM_W'({MID_LEVEL, {CH_W{1'b0}}}));
		end
	end

	// Stage 5: clamp and drop the fraction
	always_ff @(posedge clk) begin
		if (adv.s5) begin
			if (num_s4[NUM_W-1]) begin
				res_s5 <= '0;
			end else if (|num_s4[NUM_W-2:2*CH_W]) begin
				res_s5 <= CH_MAX;
			end else begin
				res_s5 <= num_s4[2*CH_W-1:CH_W];
			end
		end
	end

	assign pix_out = res_s5;

endmodule
`default_nettype wire

[src/dark_pixel_tint_brightness_contrast_top.sv]
`default_nettype none
// An accepted input beat passes the registered stages s1 to s5 to the output beat.
// Throughput: one pixel per clock while the output is not stalled; each channel
// lane holds one gain and one contrast multiplier, each followed by a register.
// Stages drain independently, so a stalled output still lets bubbles fill.
// Reset: stage valid bits clear and the configuration registers return to their
// reset values; pipeline data registers are not reset.
// ----------------------------------------------------------------------------
// dark_pixel_tint_brightness_contrast_top
// Three channel lanes in parallel behind a shared dark-pixel detector, with
// stream handshake control and the configuration registers.
// ----------------------------------------------------------------------------
module dark_pixel_tint_brightness_contrast_top (
	input  wire                             clk,
	input  wire                             arst_n,
	// Input pixel stream
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire [dptbc_pkg::PIX_W-1:0]      s_tdata,  // blue_in, green_in, red_in
	// Output pixel stream
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [dptbc_pkg::PIX_W-1:0]     m_tdata,  // blue_out, green_out, red_out
	// Configuration write port
	input  wire                             cfg_we,
	input  wire [dptbc_pkg::IDX_W-1:0]      cfg_index,
	input  wire [dptbc_pkg::CFG_W-1:0]      cfg_data
);
	import dptbc_pkg::*;

	localparam int SUM3_W = CH_W + 2;

	logic [GAIN_W-1:0]       gain_q [NUM_LANES];
	logic signed [OFF_W-1:0] offset_q;
	logic [CF_W-1:0]         contrast_q;
	logic [THR_W-1:0]        thr_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	dptbc_adv_t              adv;
	dptbc_cfg_t              cfg;
	logic [SUM3_W-1:0]       chan_sum;
	logic [SUM3_W-1:0]       thr3;
	logic                    dark_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0]  <= GAIN_RST;
			gain_q[1]  <= GAIN_RST;
			gain_q[2]  <= GAIN_RST;
			offset_q   <= OFF_RST;
			contrast_q <= CF_RST;
			thr_q      <= THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_BLUE:  gain_q[0]  <= cfg_data[GAIN_W-1:0];
				REG_GAIN_GREEN: gain_q[1]  <= cfg_data[GAIN_W-1:0];
				REG_GAIN_RED:   gain_q[2]  <= cfg_data[GAIN_W-1:0];
				REG_BRIGHTNESS: offset_q   <= cfg_data[OFF_W-1:0];
				REG_CONTRAST:   contrast_q <= cfg_data[CF_W-1:0];
				REG_DARK_THR:   thr_q      <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.offset   = offset_q;
	assign cfg.contrast = contrast_q;

	// Stage advance: a stage moves when it is empty or the next one moves
	always_comb begin
		adv.s5 = !v5_s5 || m_tready;
		adv.s4 = !v4_s4 || adv.s5;
		adv.s3 = !v3_s3 || adv.s4;
		adv.s2 = !v2_s2 || adv.s3;
		adv.s1 = !v1_s1 || adv.s2;
	end

	assign s_tready = adv.s1;
	assign m_tvalid = v5_s5;

	// Valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (adv.s1) v1_s1 <= s_tvalid;
			if (adv.s2) v2_s2 <= v1_s1;
			if (adv.s3) v3_s3 <= v2_s2;
			if (adv.s4) v4_s4 <= v3_s3;
			if (adv.s5) v5_s5 <= v4_s4;
		end
	end

	// Dark test: floor(sum / 3) < thr is the same as sum < 3 * thr
	always_comb begin
		chan_sum = SUM3_W'(s_tdata[CH_W-1:0]) + SUM3_W'(s_tdata[2*CH_W-1:CH_W])
			+ SUM3_W'(s_tdata[3*CH_W-1:2*CH_W]);
		thr3 = SUM3_W'({thr_q, 1'b0}) + SUM3_W'(thr_q);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			dark_s1 <= chan_sum < thr3;
		end
	end

	// Channel lanes; outputs merge into one beat
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		dptbc_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.pix_in  (s_tdata[k*CH_W +: CH_W]),
			.dark_s1 (dark_s1),
			.gain    (gain_q[k]),
			.cfg     (cfg),
			.pix_out (m_tdata[k*CH_W +: CH_W])
		);
	end

endmodule
`default_nettype wire

[tb/sv/tb_dark_pixel_tint_brightness_contrast_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dark pixel tint, brightness and contrast testbench
// Streams BGR pixels through the pipeline and checks every output beat
// against a predictor of the gain, offset and contrast arithmetic. A
// directed table covers the field extremes and the corner settings first,
// then random phases run with random settings and random stalls.
// ----------------------------------------------------------------------------
module tb_dark_pixel_tint_brightness_contrast_top;
	import dptbc_pkg::*;

	// Register indexes beyond the list; writes there must be ignored
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [IDX_W-1:0] REG_LIST [6] = '{REG_GAIN_BLUE, REG_GAIN_GREEN,
		REG_GAIN_RED, REG_BRIGHTNESS, REG_CONTRAST, REG_DARK_THR};
	localparam int Q_ONE      = 256;
	localparam int PHASES     = 6;
	localparam int PHASE_PIX  = 100;
	localparam int HOLD_LEN   = 300;
	localparam int DRAIN_WAIT = 20;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [CFG_W-1:0]   data;
		logic [PIX_W-1:0]   pix;
		logic               typed;
		logic [PIX_W-1:0]   want;
	} plan_row_t;

	// Directed table: pixels are {red, green, blue}
	localparam int PLAN_LEN = 42;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h000000, 1'b1, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h00FF80, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h123456, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h636363, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h646464, 1'b0, 24'h000000},
		// gain saturation and zero gain
		'{ROW_WRITE, REG_GAIN_BLUE,  12'hFFF, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_GAIN_GREEN, 12'h800, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_GAIN_RED,   12'h000, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h0A3263, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h010101, 1'b0, 24'h000000},
		// zero threshold, written with excess upper bits
		'{ROW_WRITE, REG_DARK_THR,   12'hF00, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h1E140A, 1'b1, 24'h1E140A},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h000000, 1'b1, 24'h000000},
		'{ROW_WRITE, REG_DARK_THR,   12'h0FF, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'hFEFEFE, 1'b0, 24'h000000},
		// full-range negative offset
		'{ROW_WRITE, REG_BRIGHTNESS, 12'h100, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'hFFFFFF, 1'b1, 24'h000000},
		'{ROW_WRITE, REG_BRIGHTNESS, 12'h0FF, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h000000, 1'b1, 24'hFFFFFF},
		'{ROW_WRITE, REG_BRIGHTNESS, 12'h101, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h808080, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_BRIGHTNESS, 12'hE05, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h7F8081, 1'b0, 24'h000000},
		// zero and maximum contrast
		'{ROW_WRITE, REG_CONTRAST,   12'h000, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'hA5C3E1, 1'b1, 24'h808080},
		'{ROW_WRITE, REG_CONTRAST,   12'hFFF, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h7F8081, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h00FF40, 1'b0, 24'h000000},
		// writes to indexes beyond the list
		'{ROW_WRITE, REG_SPARE_A,    12'hFFF, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_SPARE_B,    12'h000, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h7F8081, 1'b0, 24'h000000},
		// back to reset settings
		'{ROW_WRITE, REG_GAIN_BLUE,  12'h100, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_GAIN_GREEN, 12'h100, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_GAIN_RED,   12'h100, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_BRIGHTNESS, 12'h000, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_CONTRAST,   12'h100, 24'h000000, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_DARK_THR,   12'h064, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h1E140A, 1'b1, 24'h1E140A},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'hAA5500, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_GAIN_GREEN, 12'h180, 24'h000000, 1'b0, 24'h000000},
		'{ROW_PIXEL, REG_GAIN_BLUE,  12'h000, 24'h204060, 1'b0, 24'h000000}
	};

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [PIX_W-1:0] s_tdata   = '0;  // blue_in, green_in, red_in
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [PIX_W-1:0] m_tdata;         // blue_out, green_out, red_out
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Settings as the block should hold them
	logic [GAIN_W-1:0]       gain_q [NUM_LANES];
	logic signed [OFF_W-1:0] offset_q;
	logic [CF_W-1:0]         contrast_q;
	logic [THR_W-1:0]        thresh_q;

	logic [PIX_W-1:0] expected_pixels [$];
	int               mismatch_count = 0;
	bit               tx_idling_on   = 1'b1;
	bit               rx_idling_on   = 1'b1;
	bit               rx_hold_req    = 1'b0;

	dark_pixel_tint_brightness_contrast_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Gain for dark pixels, then offset with clamp, then contrast about mid level
	function automatic logic [PIX_W-1:0] tint_adjust(input logic [PIX_W-1:0] pix);
		int sum;
		int mean;
		int level;
		int acc;
		logic [PIX_W-1:0] res;
		sum = 0;
		res = '0;
		for (int k = 0; k < NUM_LANES; k++)
			sum += int'(pix[k*CH_W +: CH_W]);
		mean = sum / NUM_LANES;
		for (int k = 0; k < NUM_LANES; k++) begin
			level = int'(pix[k*CH_W +: CH_W]);
			if (mean < int'(thresh_q)) begin
				acc = level * int'(gain_q[k]);
				level = (acc > int'(CH_MAX) * Q_ONE) ? int'(CH_MAX) : acc / Q_ONE;
			end
			level += int'(offset_q);
			if (level > int'(CH_MAX))
				level = int'(CH_MAX);
			else if (level < 0)
				level = 0;
			acc = int'(MID_LEVEL) * Q_ONE + (level - int'(MID_LEVEL)) * int'(contrast_q);
			if (acc > int'(CH_MAX) * Q_ONE)
				level = int'(CH_MAX);
			else if (acc < 0)
				level = 0;
			else
				level = acc / Q_ONE;
			res[k*CH_W +: CH_W] = CH_W'(level);
		end
		return res;
	endfunction

	// Write one register, mirror it, then lower the strobe
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_GAIN_BLUE:  gain_q[0]  = data[GAIN_W-1:0];
			REG_GAIN_GREEN: gain_q[1]  = data[GAIN_W-1:0];
			REG_GAIN_RED:   gain_q[2]  = data[GAIN_W-1:0];
			REG_BRIGHTNESS: offset_q   = data[OFF_W-1:0];
			REG_CONTRAST:   contrast_q = data[CF_W-1:0];
			REG_DARK_THR:   thresh_q   = data[THR_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel, optionally after a gap, and log its expected output
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
		input logic [PIX_W-1:0] want);
		if (tx_idling_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
		expected_pixels.push_back(typed ? want : tint_adjust(pix));
	endtask

	// Stop offering and wait for every outstanding pixel
	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random stall bursts, and one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				rx_hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_idling_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each output beat with the oldest expected pixel
	always @(posedge clk) begin
		logic [PIX_W-1:0] want;
		if (m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected output beat %h", $realtime, m_tdata);
			end else begin
				want = expected_pixels.pop_front();
				if (want != m_tdata) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch b/g/r expected %0d/%0d/%0d got %0d/%0d/%0d",
							$realtime, want[7:0], want[15:8], want[23:16],
							m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
				end
			end
		end
	end

	// Stimulus: reset, directed table, random phases, final drain
	initial begin
		logic [CFG_W-1:0] value;
		logic [PIX_W-1:0] pix;
		int sel;
		gain_q     = '{GAIN_RST, GAIN_RST, GAIN_RST};
		offset_q   = OFF_RST;
		contrast_q = CF_RST;
		thresh_q   = THR_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; hold writes until the pipeline is empty
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_WRITE) begin
				drain();
				cfg_write(PLAN[r].idx, PLAN[r].data);
			end else begin
				send_pixel(PLAN[r].pix, PLAN[r].typed, PLAN[r].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			// New settings per phase, extremes among them; upper bits left random
			for (int r = 0; r < 6; r++) begin
				sel = $urandom_range(0, 5);
				case (REG_LIST[r])
					REG_BRIGHTNESS: begin
						case (sel)
							0: value = 12'h101;
							1: value = 12'h0FF;
							2: value = 12'h100;
							default: value = CFG_W'($urandom_range(0, 128) - 64);
						endcase
						value[CFG_W-1:OFF_W] = (CFG_W-OFF_W)'($urandom);
					end
					REG_DARK_THR: begin
						case (sel)
							0: value = 12'h000;
							1: value = 12'h0FF;
							2: value = CFG_W'($urandom_range(0, 255));
							default: value = CFG_W'($urandom_range(60, 150));
						endcase
						value[CFG_W-1:THR_W] = (CFG_W-THR_W)'($urandom);
					end
					default: begin
						case (sel)
							0: value = 12'h000;
							1: value = 12'hFFF;
							2: value = CFG_W'($urandom);
							default: value = CFG_W'($urandom_range(200, 800));
						endcase
					end
				endcase
				cfg_write(REG_LIST[r], value);
			end
			if ($urandom_range(0, 1) == 0)
				cfg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
					CFG_W'($urandom));

			if (p == PHASES - 1) begin
				tx_idling_on = 1'b0;
				rx_idling_on = 1'b0;
			end
			if (p == 2) begin
				tx_idling_on = 1'b0;
				rx_hold_req  = 1'b1;
			end

			for (int i = 0; i < PHASE_PIX; i++) begin
				// Back-pressure stretch is over: resume sender gaps
				if (p == 2 && i == 60)
					tx_idling_on = 1'b1;
				// Pause the sender once until everything is out
				if (p == 1 && i == PHASE_PIX / 2)
					drain();
				case ($urandom_range(0, 3))
					0: for (int k = 0; k < NUM_LANES; k++)
						pix[k*CH_W +: CH_W] = CH_W'($urandom_range(0, 120));
					1: for (int k = 0; k < NUM_LANES; k++) begin
						case ($urandom_range(0, 6))
							0: pix[k*CH_W +: CH_W] = 8'd0;
							1: pix[k*CH_W +: CH_W] = 8'd1;
							2: pix[k*CH_W +: CH_W] = 8'd127;
							3: pix[k*CH_W +: CH_W] = MID_LEVEL;
							4: pix[k*CH_W +: CH_W] = 8'd129;
							5: pix[k*CH_W +: CH_W] = 8'd254;
							default: pix[k*CH_W +: CH_W] = CH_MAX;
						endcase
					end
					default: pix = PIX_W'($urandom);
				endcase
				send_pixel(pix, 1'b0, '0);
			end
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
src/dptbc_pkg.sv
src/dptbc_lane.sv
src/dark_pixel_tint_brightness_contrast_top.sv
tb/sv/tb_dark_pixel_tint_brightness_contrast_top.sv
